// ----- rtl/core/kdj_oscillator_stream_top_defines.svh -----
// Assertion helpers for the KDJ oscillator block.
`ifndef KDJ_OSCILLATOR_STREAM_TOP_DEFINES_SVH
`define KDJ_OSCILLATOR_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define KDJ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kdj check failed");

// Next-cycle implication, sampled on clk and ignored during reset.
`define KDJ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kdj check failed");

`endif

// ----- rtl/core/kdj_pkg.sv -----
`timescale 1ns / 1ps
package kdj_pkg;
  localparam int MaxWindow = 64;
  localparam int MaxSmooth = 16;
  localparam int PriceBits = 32;

  localparam int WinAw   = $clog2(MaxWindow);
  localparam int HisAw   = $clog2(MaxSmooth);
  localparam int WlenW   = 7;
  localparam int SlenW   = 5;
  localparam int LineW   = 15;
  localparam int JW      = 18;
  localparam int SeenCap = MaxWindow + MaxSmooth;
  localparam int SeenW   = $clog2(SeenCap + 1);
  localparam int CntW    = $clog2(MaxWindow + 1);
  localparam int SumW    = LineW + HisAw;
  localparam int KDivSteps = LineW;
  localparam int DDivSteps = SumW;
  localparam int QW      = DDivSteps;
  localparam int RemW    = PriceBits + LineW;
  localparam int DshW    = PriceBits + DDivSteps;

  localparam logic [LineW-1:0] NEUTRAL    = LineW'(12800);
  localparam logic [LineW-1:0] FULL_SCALE = LineW'(25600);

  localparam logic [1:0] CROSS_NONE = 2'd0;
  localparam logic [1:0] CROSS_UP   = 2'd1;
  localparam logic [1:0] CROSS_DOWN = 2'd2;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_SMOOTH = 1'b1;

  typedef struct packed {
    logic            accept;
    logic            scan_rd;
    logic            scan_fold;
    logic            scan_first;
    logic            k_eval;
    logic            div_step;
    logic            push;
    logic            sum_rd;
    logic            sum_fold;
    logic            sum_first;
    logic            d_start;
    logic            fin;
    logic [CntW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic             kv;
    logic             dv;
    logic             need_div;
    logic             out_busy;
    logic [WlenW-1:0] n;
    logic [SlenW-1:0] m;
  } status_t;
endpackage

// ----- rtl/core/kdj_ctrl.sv -----
`timescale 1ns / 1ps
module kdj_ctrl import kdj_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_KEVAL  = 4'd2;
  localparam logic [3:0] S_KDIV   = 4'd3;
  localparam logic [3:0] S_PUSH   = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DDIV   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]      state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic [CntW-1:0] m_ext;

  assign m_ext    = CntW'(status.m);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
          cnt_next   = '0;
        end
      end
      S_SCAN: begin
        if (!status.kv) begin
          state_next = S_KEVAL;
        end else begin
          cmd.scan_rd    = (cnt < status.n);
          cmd.scan_fold  = (cnt != '0);
          cmd.scan_first = (cnt == CntW'(1));
          cnt_next       = cnt + CntW'(1);
          if (cnt == status.n) state_next = S_KEVAL;
        end
      end
      S_KEVAL: begin
        cmd.k_eval = 1'b1;
        cnt_next   = '0;
        state_next = (status.kv && status.need_div) ? S_KDIV : S_PUSH;
      end
      S_KDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CntW'(1);
        if (cnt == CntW'(KDivSteps - 1)) state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        cnt_next   = '0;
        state_next = status.dv ? S_SUM : S_FIN;
      end
      S_SUM: begin
        cmd.sum_rd    = (cnt < m_ext);
        cmd.sum_fold  = (cnt != '0);
        cmd.sum_first = (cnt == CntW'(1));
        cnt_next      = cnt + CntW'(1);
        if (cnt == m_ext) state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.d_start = 1'b1;
        cnt_next    = '0;
        state_next  = S_DDIV;
      end
      S_DDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CntW'(1);
        if (cnt == CntW'(DDivSteps - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end
endmodule

// ----- rtl/core/kdj_dp.sv -----
`timescale 1ns / 1ps
module kdj_dp import kdj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [WlenW-1:0]     cfg_data,
  input  logic [PriceBits-1:0] bar_high,
  input  logic [PriceBits-1:0] bar_low,
  input  logic [PriceBits-1:0] bar_close,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LineW-1:0]     k_line,
  output logic [LineW-1:0]     d_line,
  output logic signed [JW-1:0] j_line,
  output logic                 k_valid,
  output logic                 d_valid,
  output logic [1:0]           cross_signal
);
  logic [WlenW-1:0] wlen;
  logic [SlenW-1:0] slen;

  logic [PriceBits-1:0] hwin [MaxWindow];
  logic [PriceBits-1:0] lwin [MaxWindow];
  logic [LineW-1:0]     khist [MaxSmooth];

  logic [WinAw-1:0]     wp, base;
  logic [HisAw-1:0]     kp, kbase;
  logic [PriceBits-1:0] hrd, lrd, hh, ll, close_r;
  logic [LineW-1:0]     krd;
  logic [SeenW-1:0]     seen, seen_next;
  logic [WlenW-1:0]     n_r, n_cl;
  logic [SlenW-1:0]     m_r, m_cl;
  logic                 kv, dv, first;
  logic [SumW-1:0]      sum;
  logic [RemW-1:0]      rem;
  logic [DshW-1:0]      dsh;
  logic [QW-1:0]        q;
  logic                 kdiv;
  logic [LineW-1:0]     kreg, kval, dval, prev_k, prev_d;
  logic [LineW-1:0]     kq;
  logic                 need;
  logic [PriceBits-1:0] num, den;
  logic                 ge;
  logic [JW-1:0]        jval;
  logic [1:0]           sig;

  assign n_cl = (wlen == '0) ? WlenW'(1) :
                (wlen > WlenW'(MaxWindow)) ? WlenW'(MaxWindow) : wlen;
  assign m_cl = (slen == '0) ? SlenW'(1) :
                (slen > SlenW'(MaxSmooth)) ? SlenW'(MaxSmooth) : slen;
  assign seen_next = (seen < SeenW'(SeenCap)) ? seen + SeenW'(1) : seen;

  assign status.kv       = kv;
  assign status.dv       = dv;
  assign status.need_div = need;
  assign status.out_busy = out_valid && !out_ready;
  assign status.n        = n_r;
  assign status.m        = m_r;

  // K before any division: covers flat, outside and saturated windows.
  always_comb begin
    kq   = NEUTRAL;
    need = 1'b0;
    num  = '0;
    den  = '0;
    if (hh == ll) begin
      kq = NEUTRAL;
    end else if (hh > ll) begin
      num = close_r - ll;
      den = hh - ll;
      if (close_r <= ll) kq = '0;
      else if (num >= den) kq = FULL_SCALE;
      else need = 1'b1;
    end else begin
      num = ll - close_r;
      den = ll - hh;
      if (close_r >= ll) kq = '0;
      else if (num >= den) kq = FULL_SCALE;
      else need = 1'b1;
    end
  end

  assign ge   = ({{(DshW-RemW){1'b0}}, rem} >= dsh);
  assign kval = kdiv ? q[LineW-1:0] : kreg;
  assign dval = dv ? q[LineW-1:0] : NEUTRAL;
  assign jval = kv ? (JW'(kreg) + JW'({kreg, 1'b0}) - JW'({dval, 1'b0})) : JW'(NEUTRAL);

  always_comb begin
    sig = CROSS_NONE;
    if (!first) begin
      if (kreg > dval && prev_k <= prev_d) sig = CROSS_UP;
      else if (kreg < dval && prev_k >= prev_d) sig = CROSS_DOWN;
    end
  end

  // Window and history stores: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hwin[wp] <= bar_high;
      lwin[wp] <= bar_low;
    end
    if (cmd.scan_rd) begin
      hrd <= hwin[base - cmd.idx[WinAw-1:0]];
      lrd <= lwin[base - cmd.idx[WinAw-1:0]];
    end
    if (cmd.push) khist[kp] <= kval;
    if (cmd.sum_rd) krd <= khist[kbase - cmd.idx[HisAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      close_r <= bar_close;
      base    <= wp;
      n_r     <= n_cl;
      m_r     <= m_cl;
      first   <= (seen == '0);
      kv      <= (seen_next >= SeenW'(n_cl));
      dv      <= ({1'b0, seen_next} >= ({1'b0, n_cl} + (SeenW+1)'(m_cl) - (SeenW+1)'(1)));
    end
    if (cmd.scan_fold) begin
      if (cmd.scan_first || hrd > hh) hh <= hrd;
      if (cmd.scan_first || lrd < ll) ll <= lrd;
    end
    if (cmd.k_eval) begin
      kreg <= kv ? kq : NEUTRAL;
      kdiv <= kv && need;
      rem  <= RemW'(num) * RemW'(FULL_SCALE);
      dsh  <= DshW'({den, {(KDivSteps-1){1'b0}}});
      q    <= '0;
    end
    if (cmd.div_step) begin
      if (ge) rem <= rem - dsh[RemW-1:0];
      dsh <= dsh >> 1;
      q   <= {q[QW-2:0], ge};
    end
    if (cmd.push) begin
      kreg  <= kval;
      kbase <= kp;
    end
    if (cmd.sum_fold) sum <= (cmd.sum_first ? '0 : sum) + SumW'(krd);
    if (cmd.d_start) begin
      rem <= RemW'(sum);
      dsh <= DshW'({m_r, {(DDivSteps-1){1'b0}}});
      q   <= '0;
    end
    if (cmd.fin) begin
      k_line       <= kreg;
      d_line       <= dval;
      j_line       <= $signed(jval);
      k_valid      <= kv;
      d_valid      <= dv;
      cross_signal <= sig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen      <= WlenW'(9);
      slen      <= SlenW'(3);
      wp        <= '0;
      kp        <= '0;
      seen      <= '0;
      prev_k    <= NEUTRAL;
      prev_d    <= NEUTRAL;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index[0] == REG_WINDOW) wlen <= cfg_data;
      if (cfg_we && cfg_index[0] == REG_SMOOTH) slen <= cfg_data[SlenW-1:0];
      if (cmd.accept) begin
        wp   <= wp + WinAw'(1);
        seen <= seen_next;
      end
      if (cmd.push) kp <= kp + HisAw'(1);
      if (cmd.fin) begin
        prev_k    <= kreg;
        prev_d    <= dval;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/core/kdj_oscillator_stream_top.sv -----
`timescale 1ns / 1ps
// KDJ stochastic oscillator, one price bar per input beat.
// Input channel: in_valid/in_ready with bar_high, bar_low and bar_close.
// Output channel: out_valid/out_ready with k_line, d_line, j_line, k_valid,
// d_valid and cross_signal; every input beat yields exactly one output beat.
// Configuration: cfg_we writes cfg_data into window_length (index 0) or
// smooth_length (index 1) at once; write only while the block is idle.
// The work per bar grows with N, the clamped window length (1 to 64), and M,
// the clamped smoothing length (1 to 16): the high/low scan reads one window
// entry a cycle, K may need a 15-step restoring division, and once D is
// valid the D sum reads one history entry a cycle and D needs a 19-step
// division on the same divider. The block works on one bar at a time.
// The result sits in an output register, so a new bar is taken while the
// previous result still waits; if the receiver stalls, the finished result
// of the next bar is held back until the output register frees.
// Reset clears the bar count, the previous K and D (to neutral 50), the
// store pointers and the output valid, and restores lengths 9 and 3.
module kdj_oscillator_stream_top import kdj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [WlenW-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PriceBits-1:0] bar_high,
  input  logic [PriceBits-1:0] bar_low,
  input  logic [PriceBits-1:0] bar_close,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LineW-1:0]     k_line,
  output logic [LineW-1:0]     d_line,
  output logic signed [JW-1:0] j_line,
  output logic                 k_valid,
  output logic                 d_valid,
  output logic [1:0]           cross_signal
);
`include "kdj_oscillator_stream_top_defines.svh"

  cmd_t    cmd;
  status_t status;

  // The controller sequences scan, division, history and output steps.
  kdj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the stores, the shared divider and the output register.
  kdj_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bar_high     (bar_high),
    .bar_low      (bar_low),
    .bar_close    (bar_close),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .k_line       (k_line),
    .d_line       (d_line),
    .j_line       (j_line),
    .k_valid      (k_valid),
    .d_valid      (d_valid),
    .cross_signal (cross_signal)
  );

  // An accepted bar keeps the block busy for at least the next cycle.
  `KDJ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // D can only be valid once K is valid.
  `KDJ_ASSERT_SAME(a_d_needs_k, out_valid && d_valid, k_valid)
  // During K warm-up all three lines sit at neutral.
  `KDJ_ASSERT_SAME(a_warmup_neutral, out_valid && !k_valid,
    k_line == NEUTRAL && d_line == NEUTRAL && j_line == JW'(NEUTRAL))
  // Without a valid D the D line is neutral.
  `KDJ_ASSERT_SAME(a_d_neutral, out_valid && !d_valid, d_line == NEUTRAL)
endmodule
